[rtl/core/fpps_pkg.sv]
// ----------------------------------------------------------------------------
// Flash page program sequencer package
// Shared constants, command codes and the structs passed between the front,
// the job queue, the page buffer and the back.
// ----------------------------------------------------------------------------
package fpps_pkg;

  localparam int unsigned PAGE_BYTES  = 64;
  localparam int unsigned ERASE_BYTES = 1024;
  localparam int unsigned ADDR_BITS   = 24;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned WIDX_W      = 3;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORDS       = PAGE_BYTES / 8;
  localparam int unsigned OFF_BITS    = $clog2(PAGE_BYTES);
  localparam int unsigned WIDX_BITS   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] PAGE_MASK  = ~ADDR_W'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ERASE_MASK = ~ADDR_W'(ERASE_BYTES - 1);

  typedef enum logic [1:0] {
    CMD_ERASE = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic              error;
    logic              drain;
    logic              erase;
    logic              bank;
    logic [ADDR_W-1:0] page_addr;
    logic [ADDR_W-1:0] aux_addr;
  } job_t;

  typedef struct packed {
    logic                en;
    logic                open;
    logic                bank;
    logic [OFF_BITS-1:0] offset;
    logic [7:0]          data;
  } pbuf_wr_t;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [WIDX_BITS-1:0] widx;
  } pbuf_rd_t;

  typedef struct packed {
    logic en;
    logic bank;
  } busy_clr_t;

endpackage

[rtl/core/flash_page_program_sequencer.sv]
// ----------------------------------------------------------------------------
// Flash page program sequencer
// Throughput: 1 request/cycle unless a needed push finds the queue full or the bank to open is still draining;
// a drain is 8 words at 1/cycle while the output is not stalled.
// Reset: clears the open page, erased region, queue and buffer valid bits.
// ----------------------------------------------------------------------------
module flash_page_program_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[23:0], data_byte[31:24]
  input  logic        s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // cmd_address[23:0], word_index[26:24],
                                      // data_word[90:27], zero[95:91]
  output logic [1:0]  m_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tlast
);

  logic                          push;
  logic                          pop;
  logic                          fifo_full;
  logic                          fifo_empty;
  fpps_pkg::job_t                job_in;
  fpps_pkg::job_t                job_out;
  fpps_pkg::pbuf_wr_t            wr;
  fpps_pkg::pbuf_rd_t            rd;
  fpps_pkg::busy_clr_t           clr;
  logic [fpps_pkg::WORD_W-1:0]   rdata;
  fpps_pkg::cmd_e                cmd;
  logic [fpps_pkg::ADDR_W-1:0]   cmd_addr;
  logic [fpps_pkg::WIDX_W-1:0]   widx;
  logic                          is_word;

  fpps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .address_i   (s_axis_tdata[23:0]),
    .data_byte_i (s_axis_tdata[31:24]),
    .push_o      (push),
    .job_o       (job_in),
    .fifo_full_i (fifo_full),
    .wr_o        (wr),
    .clr_i       (clr)
  );

  fpps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .job_o   (job_out)
  );

  fpps_pbuf u_pbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  fpps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .rd_o         (rd),
    .clr_o        (clr),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .cmd_o        (cmd),
    .addr_o       (cmd_addr),
    .widx_o       (widx),
    .is_word_o    (is_word),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = cmd;
  assign m_axis_tdata = {5'b0, (is_word ? rdata : {fpps_pkg::WORD_W{1'b0}}), widx, cmd_addr};

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_full)
    else $error("job queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_empty)
    else $error("job queue underflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && rd.en) |-> (wr.bank != rd.bank))
    else $error("page buffer bank written while draining");

endmodule

[rtl/core/fpps_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts request transfers, tracks the open page and the erased region,
// writes bytes into the page buffer and queues jobs for the back end.
// ----------------------------------------------------------------------------
module fpps_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic                        req_type_i,
  input  logic [fpps_pkg::ADDR_W-1:0] address_i,
  input  logic [7:0]                  data_byte_i,
  output logic                        push_o,
  output fpps_pkg::job_t              job_o,
  input  logic                        fifo_full_i,
  output fpps_pkg::pbuf_wr_t          wr_o,
  input  fpps_pkg::busy_clr_t         clr_i
);

  logic                          page_open_q, page_open_d;
  logic [fpps_pkg::ADDR_W-1:0]   page_start_q, page_start_d;
  logic [fpps_pkg::ADDR_W:0]     erased_limit_q, erased_limit_d;
  logic                          cur_bank_q, cur_bank_d;
  logic [1:0]                    busy_q, busy_d;

  logic [fpps_pkg::ADDR_W-1:0]   addr;
  logic [fpps_pkg::ADDR_W:0]     page_end;
  logic [fpps_pkg::ADDR_W-1:0]   new_start;
  logic [fpps_pkg::ADDR_W-1:0]   blk;
  logic                          below;
  logic                          opening;
  logic                          erase_need;
  logic                          need_push;
  logic                          acc;

  always_comb begin
    addr       = address_i & fpps_pkg::ADDR_MASK;
    page_end   = {1'b0, page_start_q} + (fpps_pkg::ADDR_W + 1)'(fpps_pkg::PAGE_BYTES);
    new_start  = addr & fpps_pkg::PAGE_MASK;
    blk        = new_start & fpps_pkg::ERASE_MASK;
    below      = page_open_q && (addr < page_start_q);
    opening    = !req_type_i && !below && (!page_open_q || ({1'b0, addr} >= page_end));
    erase_need = {1'b0, new_start} >= erased_limit_q;

    job_o.error     = !req_type_i && below;
    job_o.drain     = req_type_i ? page_open_q : (opening && page_open_q);
    job_o.erase     = opening && erase_need;
    job_o.bank      = cur_bank_q;
    job_o.page_addr = page_start_q;
    job_o.aux_addr  = below ? addr : blk;
    need_push       = job_o.error || job_o.drain || job_o.erase;

    s_ready_o = !(need_push && fifo_full_i) && !(opening && busy_q[~cur_bank_q]);
    acc       = s_valid_i && s_ready_o;
    push_o    = acc && need_push;

    wr_o.en     = acc && !req_type_i && !below;
    wr_o.open   = opening;
    wr_o.bank   = opening ? ~cur_bank_q : cur_bank_q;
    wr_o.offset = addr[fpps_pkg::OFF_BITS-1:0];
    wr_o.data   = data_byte_i;
  end

  always_comb begin
    page_open_d    = page_open_q;
    page_start_d   = page_start_q;
    erased_limit_d = erased_limit_q;
    cur_bank_d     = cur_bank_q;
    busy_d         = busy_q;
    if (clr_i.en) begin
      busy_d[clr_i.bank] = 1'b0;
    end
    if (push_o && job_o.drain) begin
      busy_d[cur_bank_q] = 1'b1;
    end
    if (acc && req_type_i) begin
      page_open_d = 1'b0;
    end
    if (acc && opening) begin
      page_open_d  = 1'b1;
      page_start_d = new_start;
      cur_bank_d   = ~cur_bank_q;
      if (erase_need) begin
        erased_limit_d = {1'b0, blk} + (fpps_pkg::ADDR_W + 1)'(fpps_pkg::ERASE_BYTES);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_open_q    <= 1'b0;
      page_start_q   <= '0;
      erased_limit_q <= '0;
      cur_bank_q     <= 1'b0;
      busy_q         <= '0;
    end else begin
      page_open_q    <= page_open_d;
      page_start_q   <= page_start_d;
      erased_limit_q <= erased_limit_d;
      cur_bank_q     <= cur_bank_d;
      busy_q         <= busy_d;
    end
  end

endmodule

[rtl/core/fpps_fifo.sv]
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module fpps_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpps_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fpps_pkg::job_t job_o
);

  fpps_pkg::job_t                  mem_q [fpps_pkg::QUEUE_DEPTH];
  logic [fpps_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [fpps_pkg::QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [fpps_pkg::QCNT_BITS-1:0]  cnt_q, cnt_d;

  localparam logic [fpps_pkg::QPTR_BITS-1:0] PtrLast =
    fpps_pkg::QPTR_BITS'(fpps_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    full_o   = cnt_q == fpps_pkg::QCNT_BITS'(fpps_pkg::QUEUE_DEPTH);
    empty_o  = cnt_q == '0;
    job_o    = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/fpps_pbuf.sv]
// ----------------------------------------------------------------------------
// Page buffer
// Two banks of page storage with byte writes and word reads. Per-byte valid
// bits make unwritten bytes read as 0xFF.
// ----------------------------------------------------------------------------
module fpps_pbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpps_pkg::pbuf_wr_t          wr_i,
  input  fpps_pkg::pbuf_rd_t          rd_i,
  output logic [fpps_pkg::WORD_W-1:0] rdata_o
);

  logic [fpps_pkg::WORD_W-1:0]            mem_q [2][fpps_pkg::WORDS];
  logic [1:0][fpps_pkg::PAGE_BYTES-1:0]   vld_q;
  logic [fpps_pkg::WORD_W-1:0]            rd_q;
  logic [7:0]                             vmask_q;

  logic [fpps_pkg::WIDX_BITS-1:0]         wr_widx;
  logic [fpps_pkg::PAGE_BYTES-1:0]        wr_onehot;

  always_comb begin
    wr_widx   = fpps_pkg::WIDX_BITS'(wr_i.offset >> 3);
    wr_onehot = fpps_pkg::PAGE_BYTES'(1) << wr_i.offset;
    for (int b = 0; b < 8; b++) begin
      rdata_o[b*8 +: 8] = vmask_q[b] ? rd_q[b*8 +: 8] : 8'hFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_widx][{wr_i.offset[2:0], 3'b000} +: 8] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_q <= mem_q[rd_i.bank][rd_i.widx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vmask_q <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.bank] <= wr_i.open ? wr_onehot : (vld_q[wr_i.bank] | wr_onehot);
      end
      if (rd_i.en) begin
        vmask_q <= vld_q[rd_i.bank][{rd_i.widx, 3'b000} +: 8];
      end
    end
  end

endmodule

[rtl/core/fpps_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Takes jobs from the queue and sequences the write words, erase and error
// commands into the output register.
// ----------------------------------------------------------------------------
module fpps_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_empty_i,
  input  fpps_pkg::job_t              job_i,
  output logic                        pop_o,
  output fpps_pkg::pbuf_rd_t          rd_o,
  output fpps_pkg::busy_clr_t         clr_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output fpps_pkg::cmd_e              cmd_o,
  output logic [fpps_pkg::ADDR_W-1:0] addr_o,
  output logic [fpps_pkg::WIDX_W-1:0] widx_o,
  output logic                        is_word_o,
  output logic                        last_o
);

  typedef enum logic [2:0] {
    BK_FETCH = 3'b001,
    BK_DRAIN = 3'b010,
    BK_ERASE = 3'b100
  } back_state_e;

  back_state_e                    state_q, state_d;
  fpps_pkg::job_t                 job_q, job_d;
  logic [fpps_pkg::WIDX_BITS-1:0] cnt_q, cnt_d;
  logic                           m_valid_q, m_valid_d;
  fpps_pkg::cmd_e                 cmd_q, cmd_d;
  logic [fpps_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [fpps_pkg::WIDX_W-1:0]    widx_q, widx_d;
  logic                           is_word_q, is_word_d;
  logic                           last_q, last_d;

  logic                           load;
  fpps_pkg::job_t                 j;
  logic [fpps_pkg::WIDX_BITS-1:0] w;
  logic                           final_word;
  logic                           do_word;
  logic                           do_emit;
  fpps_pkg::cmd_e                 emit_cmd;

  always_comb begin
    load       = !m_valid_q || m_ready_i;
    j          = (state_q == BK_FETCH) ? job_i : job_q;
    w          = (state_q == BK_FETCH) ? '0 : cnt_q;
    final_word = w == fpps_pkg::WIDX_BITS'(fpps_pkg::WORDS - 1);

    state_d   = state_q;
    job_d     = job_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    do_word   = 1'b0;
    do_emit   = 1'b0;
    emit_cmd  = fpps_pkg::CMD_ERASE;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    widx_d    = widx_q;
    is_word_d = is_word_q;
    last_d    = last_q;

    unique case (state_q)
      BK_FETCH: begin
        if (load && !fifo_empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          if (job_i.error) begin
            do_emit  = 1'b1;
            emit_cmd = fpps_pkg::CMD_ERROR;
          end else if (job_i.drain) begin
            do_word = 1'b1;
          end else begin
            do_emit = 1'b1;
          end
        end
      end
      BK_DRAIN: begin
        if (load) begin
          do_word = 1'b1;
        end
      end
      BK_ERASE: begin
        if (load) begin
          do_emit = 1'b1;
          state_d = BK_FETCH;
        end
      end
      default: begin
        state_d = BK_FETCH;
      end
    endcase

    rd_o.en    = do_word;
    rd_o.bank  = j.bank;
    rd_o.widx  = w;
    clr_o.en   = do_word && final_word;
    clr_o.bank = j.bank;

    if (do_word) begin
      m_valid_d = 1'b1;
      cmd_d     = fpps_pkg::CMD_WRITE;
      addr_d    = j.page_addr;
      widx_d    = fpps_pkg::WIDX_W'(w);
      is_word_d = 1'b1;
      last_d    = final_word && !j.erase;
      if (final_word) begin
        state_d = j.erase ? BK_ERASE : BK_FETCH;
      end else begin
        state_d = BK_DRAIN;
        cnt_d   = w + 1'b1;
      end
    end
    if (do_emit) begin
      m_valid_d = 1'b1;
      cmd_d     = emit_cmd;
      addr_d    = j.aux_addr;
      widx_d    = '0;
      is_word_d = 1'b0;
      last_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    widx_q    <= widx_d;
    is_word_q <= is_word_d;
    last_q    <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_FETCH;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign cmd_o     = cmd_q;
  assign addr_o    = addr_q;
  assign widx_o    = widx_q;
  assign is_word_o = is_word_q;
  assign last_o    = last_q;

endmodule
